>>> rtl/msup_pkg.sv
// Shared types, codes and constants for the motor supervisor.
package msup_pkg;

    localparam int unsigned OP_W       = 3;
    localparam int unsigned ANG_W      = 14;
    localparam int unsigned CNT_W      = 13;
    localparam int unsigned SUM_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned OUT_DATA_W = 96;

    localparam logic [ANG_W-1:0] THIRD_TURN = ANG_W'(16'h4000 / 3);
    localparam logic [15:0]      STALL_CUR  = 16'd200;
    localparam logic [31:0]      STALL_HOLD = 32'd500;
    localparam logic [31:0]      ARM_TMO    = 32'd1000;

    // Reset values of the configuration registers
    localparam logic [15:0]      RST_INIT_DLY = 16'd500;
    localparam logic [15:0]      RST_STEP_DLY = 16'd10;
    localparam logic [CNT_W-1:0] RST_NSAMP    = CNT_W'(256);
    localparam logic [ANG_W-1:0] RST_ASTEP    = ANG_W'(64);
    localparam logic [15:0]      RST_HVEL     = 16'hFF9C;

    typedef enum logic [2:0] {
        REG_INVERT = 3'd0, REG_INIT_DLY = 3'd1, REG_STEP_DLY = 3'd2,
        REG_NSAMP = 3'd3, REG_ASTEP = 3'd4, REG_HVEL = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0, OP_ERROR = 3'd1, OP_DISARM = 3'd2,
        OP_ARM = 3'd3, OP_CAL = 3'd4, OP_HOME = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_STARTUP = 3'd0, ST_DISARMED = 3'd1, ST_ERROR = 3'd2,
        ST_ARMED = 3'd3, ST_HOMING = 3'd4, ST_CAL = 3'd5
    } t_top;

    typedef enum logic [2:0] {
        SUB_NULL = 3'd0, SUB_HOLD_THIRD = 3'd1, SUB_HOLD_ZERO = 3'd2,
        SUB_SAMPLE = 3'd3, SUB_STEP = 3'd4
    } t_sub;

    typedef enum logic [2:0] {
        ERR_OK = 3'd0, ERR_TIMEOUT = 3'd1, ERR_LINK = 3'd2,
        ERR_SIGNAL = 3'd3, ERR_OTHER = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        FOC_STOP = 2'd0, FOC_VOLT = 2'd1, FOC_CURR = 2'd2
    } t_foc;

    typedef enum logic [1:0] {C_IDLE, C_DIV, C_OUT} t_ctl;

    // Controller to datapath
    typedef struct packed {
        logic load;      // register incoming word, apply event
        logic div_start; // start the offset division
        logic div_step;  // one restoring division step
        logic div_done;  // write quotient into offset
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;  // event finishes calibration with nonzero count
    } t_sts;

endpackage

>>> rtl/motor_supervisor_fsm_top.sv
// Top level of the motor supervisor: controller plus datapath.
// Usage:
//  One event word enters on s_axis (op, time, angles, current, error kind);
//  exactly one status word leaves on m_axis per event, reflecting the state
//  after that event is applied.
//  m_axis_tvalid rises in the cycle after the accept edge for most events;
//  the event that ends a calibration runs a 32-step restoring divider and
//  then writes the quotient back before its result is valid.
//  Items are processed one at a time; s_axis_tready is low while a word is
//  in work or waiting on the output.
//  If m_axis_tready is low the result holds and no new event is accepted.
//  Reset (synchronous, active low) returns to startup, clears all state except the divider registers and
//  loads the configuration defaults. Configuration writes on i_cfg_* take
//  effect at the next edge and should be made while idle.
module motor_supervisor_fsm_top
    import msup_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // operation, event_time, measured_elec_angle, measured_current_q,
    // measured_mech_angle, error_kind, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // ctrl_state, foc_mode, outer_mode, elec_angle_ref, velocity_ref,
    // homing_offset, clear_errors, break_release, error_code, offset_valid,
    // home_done, elec_offset, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);
    t_cmd w_cmd;
    t_sts w_sts;

    msup_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    msup_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_data(s_axis_tdata), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_out_data(m_axis_tdata)
    );

    // Never take a new word while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept during output");

    // Divider steps never coincide with a load
    a_div_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_step |-> !w_cmd.load) else $error("divide overlaps load");

    // A result is held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule

>>> rtl/msup_ctrl.sv
// Sequencing controller: accept, optional serial divide, present result.
module msup_ctrl
    import msup_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_ctl r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            C_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.need_div) begin
                        o_cmd.div_start = 1'b1;
                        n_cnt = 6'd0;
                        n_state = C_DIV;
                    end else begin
                        n_state = C_OUT;
                    end
                end
            end
            C_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    n_state = C_OUT;
                end
            end
            C_OUT: begin
                if (r_cnt == 6'd32) begin
                    o_cmd.div_done = 1'b1;
                    n_cnt = 6'd0;
                end else begin
                    o_out_valid = 1'b1;
                    if (i_out_ready) begin
                        n_state = C_IDLE;
                    end
                end
            end
            default: n_state = C_IDLE;
        endcase
    end
endmodule

>>> rtl/msup_dp.sv
// Datapath: supervisor state registers, event update and serial divider.
module msup_dp
    import msup_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [OUT_DATA_W-1:0] o_out_data
);
    // Configuration
    logic              r_inv;
    logic [15:0]       r_init_dly, r_step_dly, r_hvel;
    logic [CNT_W-1:0]  r_nsamp;
    logic [ANG_W-1:0]  r_astep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= 1'b0; r_init_dly <= RST_INIT_DLY; r_step_dly <= RST_STEP_DLY;
            r_nsamp <= RST_NSAMP; r_astep <= RST_ASTEP; r_hvel <= RST_HVEL;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_INVERT:   r_inv <= i_cfg_data[0];
                REG_INIT_DLY: r_init_dly <= i_cfg_data;
                REG_STEP_DLY: r_step_dly <= i_cfg_data;
                REG_NSAMP:    r_nsamp <= i_cfg_data[CNT_W-1:0];
                REG_ASTEP:    r_astep <= i_cfg_data[ANG_W-1:0];
                REG_HVEL:     r_hvel <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input fields
    logic [2:0]  w_op, w_kind;
    logic [31:0] w_now, w_mech;
    logic [ANG_W-1:0] w_meas;
    logic signed [15:0] w_iq;
    assign w_op   = i_in_data[2:0];
    assign w_now  = i_in_data[34:3];
    assign w_meas = i_in_data[48:35];
    assign w_iq   = i_in_data[64:49];
    assign w_mech = i_in_data[96:65];
    assign w_kind = i_in_data[99:97];

    // State
    t_top r_top, n_top;
    t_sub r_sub, n_sub;
    logic [31:0] r_start, n_start;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [2:0] r_err, n_err;
    logic [ANG_W-1:0] r_aref, n_aref;
    logic [1:0] r_foc, n_foc;
    logic r_vel, n_vel, r_clr, n_clr, r_offok, n_offok, r_homeok, n_homeok;
    logic [15:0] r_vref, n_vref;
    logic [31:0] r_hoff, n_hoff;
    logic [ANG_W-1:0] r_off;
    logic r_brk, n_brk, n_div;

    // Divider registers: magnitude restoring divide
    logic [31:0] r_quo, r_rem;
    logic [CNT_W-1:0] r_dvs;
    logic r_neg;

    logic w_exp_init, w_exp_step, w_exp_hold, w_exp_arm;
    logic w_low_iq;
    logic [31:0] w_hold_base;
    assign w_exp_init = w_now > (r_start + {16'd0, r_init_dly});
    assign w_exp_step = w_now > (r_start + {16'd0, r_step_dly});
    assign w_exp_arm  = w_now > (r_start + ARM_TMO);

    // Homing: low current restarts the stall timer before the expiry test
    assign w_low_iq    = (w_iq < signed'(STALL_CUR)) && (w_iq > -signed'(STALL_CUR));
    assign w_hold_base = w_low_iq ? w_now : r_start;
    assign w_exp_hold  = w_now > (w_hold_base + STALL_HOLD);

    // Wrapped angle error
    logic [ANG_W-1:0] w_d;
    logic signed [SUM_W-1:0] w_sd;
    assign w_d  = r_aref - w_meas;
    assign w_sd = SUM_W'(signed'(w_d));

    // Event update
    always_comb begin
        n_top = r_top; n_sub = r_sub; n_start = r_start; n_cnt = r_cnt;
        n_sum = r_sum; n_err = r_err; n_aref = r_aref; n_foc = r_foc;
        n_vel = r_vel; n_clr = r_clr; n_offok = r_offok; n_homeok = r_homeok;
        n_vref = r_vref; n_hoff = r_hoff; n_brk = 1'b0; n_div = 1'b0;
        case (t_op'(w_op))
            OP_TICK: begin
                case (r_top)
                    ST_CAL: begin
                        case (r_sub)
                            SUB_HOLD_THIRD: if (w_exp_init) begin
                                n_aref = '0; n_sub = SUB_HOLD_ZERO; n_start = w_now;
                            end
                            SUB_HOLD_ZERO, SUB_STEP: begin
                                if ((r_sub == SUB_HOLD_ZERO) ? w_exp_init : w_exp_step) begin
                                    n_sum = r_sum + w_sd;
                                    n_cnt = r_cnt + 1'b1;
                                    n_sub = SUB_SAMPLE;
                                end
                            end
                            SUB_SAMPLE: begin
                                if (r_cnt < r_nsamp) begin
                                    if (r_cnt < (r_nsamp >> 1)) n_aref = r_aref + r_astep;
                                    else n_aref = r_aref - r_astep;
                                    n_sub = SUB_STEP; n_start = w_now;
                                end else begin
                                    n_div = (r_cnt != '0);
                                    n_offok = 1'b1; n_foc = FOC_STOP; n_clr = 1'b0;
                                    n_top = ST_DISARMED; n_sub = SUB_NULL;
                                end
                            end
                            default: ;
                        endcase
                    end
                    ST_HOMING: begin
                        if (w_low_iq)
                            n_start = w_now;
                        if (w_exp_hold) begin
                            n_homeok = 1'b1;
                            n_hoff = r_inv ? (32'd0 - w_mech) : w_mech;
                            n_foc = FOC_STOP; n_clr = 1'b0; n_top = ST_DISARMED;
                        end
                    end
                    ST_ARMED: if (w_exp_arm) begin
                        n_err = ERR_TIMEOUT; n_foc = FOC_STOP; n_clr = 1'b1;
                        n_top = ST_ERROR;
                    end
                    ST_STARTUP: begin
                        n_foc = FOC_STOP; n_clr = 1'b0; n_top = ST_DISARMED;
                        n_sub = SUB_NULL;
                    end
                    default: ;
                endcase
            end
            OP_ERROR: if (r_top != ST_ERROR) begin
                n_err = (w_kind == ERR_LINK || w_kind == ERR_SIGNAL || w_kind == ERR_OTHER)
                        ? w_kind : ERR_OTHER;
                n_foc = FOC_STOP;
                if (n_err == ERR_LINK || n_err == ERR_SIGNAL) n_homeok = 1'b0;
                n_clr = 1'b1; n_top = ST_ERROR;
            end
            OP_DISARM: begin
                if (r_top == ST_ARMED) begin
                    n_foc = FOC_STOP; n_clr = 1'b0; n_top = ST_DISARMED;
                end else if (r_top == ST_ERROR) begin
                    n_foc = FOC_STOP; n_clr = 1'b0; n_top = ST_DISARMED;
                    n_err = ERR_OK; n_brk = 1'b1;
                end
            end
            OP_ARM: begin
                if (r_top == ST_DISARMED) begin
                    n_foc = FOC_CURR; n_vel = 1'b0; n_vref = '0; n_top = ST_ARMED;
                    n_start = w_now;
                end else if (r_top == ST_ARMED) begin
                    n_start = w_now;
                end
            end
            OP_CAL: if (r_top == ST_DISARMED) begin
                n_foc = FOC_VOLT; n_offok = 1'b0; n_cnt = '0; n_sum = '0;
                n_aref = THIRD_TURN; n_top = ST_CAL; n_sub = SUB_HOLD_THIRD;
                n_start = w_now;
            end
            OP_HOME: if (r_top == ST_DISARMED) begin
                n_homeok = 1'b0; n_hoff = '0; n_foc = FOC_CURR; n_vel = 1'b1;
                n_vref = r_hvel; n_top = ST_HOMING; n_start = w_now;
            end
            default: ;
        endcase
    end

    assign o_sts.need_div = n_div;

    logic [31:0] w_trial;
    assign w_trial = {r_rem[30:0], r_quo[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= ST_STARTUP; r_sub <= SUB_NULL; r_start <= '0; r_cnt <= '0;
            r_sum <= '0; r_err <= ERR_OK; r_aref <= '0; r_foc <= FOC_STOP;
            r_vel <= 1'b0; r_clr <= 1'b0; r_offok <= 1'b0; r_homeok <= 1'b0;
            r_vref <= '0; r_hoff <= '0; r_off <= '0; r_brk <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_top <= n_top; r_sub <= n_sub; r_start <= n_start; r_cnt <= n_cnt;
                r_sum <= n_sum; r_err <= n_err; r_aref <= n_aref; r_foc <= n_foc;
                r_vel <= n_vel; r_clr <= n_clr; r_offok <= n_offok;
                r_homeok <= n_homeok; r_vref <= n_vref; r_hoff <= n_hoff;
                r_brk <= n_brk;
                // empty average gives zero
                if (n_offok && !r_offok && !n_div) r_off <= '0;
            end
            if (i_cmd.div_done)
                r_off <= r_neg ? ANG_W'(32'd0 - r_quo) : r_quo[ANG_W-1:0];
        end
    end

    // Serial divider, one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= r_sum[SUM_W-1] ? (32'd0 - r_sum) : r_sum;
            r_neg <= r_sum[SUM_W-1];
            r_rem <= '0;
            r_dvs <= r_cnt;
        end else if (i_cmd.div_step) begin
            if (w_trial >= {19'd0, r_dvs}) begin
                r_rem <= w_trial - {19'd0, r_dvs};
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // Result word, zero padded to whole bytes
    assign o_out_data = {7'd0, r_off, r_homeok, r_offok, r_err, r_brk, r_clr, r_hoff,
                         r_vref, r_aref, r_vel, r_foc, r_top};
endmodule

>>> sim/motor_supervisor_fsm_top_tb.sv
// Self-checking testbench for the motor supervisor: event words in, status words checked.
module motor_supervisor_fsm_top_tb;
    import msup_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Status word field layout, lowest bit first
    localparam int NUM_FLD = 12;
    localparam int FLD_LSB [NUM_FLD] = '{0, 3, 5, 6, 20, 36, 68, 69, 70, 73, 74, 75};
    localparam int FLD_WID [NUM_FLD] = '{3, 2, 1, 14, 16, 32, 1, 1, 3, 1, 1, 14};
    localparam int WDOG_LIMIT = 5000;

    // Supervisor predictor plus queue of expected status words
    class status_scoreboard;
        logic        invert;
        logic [15:0] init_dly, step_dly, hvel;
        logic [12:0] nsamp;
        logic [13:0] astep;
        t_top        top;
        t_sub        sub;
        logic [31:0] t_start;
        logic [12:0] count;
        logic signed [31:0] err_sum;
        logic [2:0]  sticky;
        logic [13:0] ang_ref;
        logic [1:0]  foc;
        logic        velmode, clr, offok, homeok;
        logic [15:0] vel_ref;
        logic [31:0] home_off;
        logic [13:0] offset;
        logic [OUT_DATA_W-1:0] status_q[$];
        int          n_fail;

        function new();
            invert = 0; init_dly = 500; step_dly = 10; nsamp = 256; astep = 64;
            hvel = 16'hFF9C; top = ST_STARTUP; sub = SUB_NULL; t_start = 0;
            count = 0; err_sum = 0; sticky = ERR_OK; ang_ref = 0; foc = FOC_STOP;
            velmode = 0; clr = 0; offok = 0; homeok = 0; vel_ref = 0; home_off = 0;
            offset = 0; n_fail = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [15:0] d);
            case (idx)
                REG_INVERT:   invert = d[0];
                REG_INIT_DLY: init_dly = d;
                REG_STEP_DLY: step_dly = d;
                REG_NSAMP:    nsamp = d[12:0];
                REG_ASTEP:    astep = d[13:0];
                REG_HVEL:     hvel = d;
                default: ;
            endcase
        endfunction

        function bit timed_out(logic [31:0] now, logic [31:0] dly);
            logic [31:0] lim;
            lim = t_start + dly;
            return now > lim;
        endfunction

        function void to_disarmed();
            foc = FOC_STOP; clr = 0; top = ST_DISARMED;
        endfunction

        function void to_error();
            foc = FOC_STOP;
            if (sticky == ERR_LINK || sticky == ERR_SIGNAL) homeok = 0;
            clr = 1; top = ST_ERROR;
        endfunction

        function void sample_angle(logic [13:0] meas);
            logic [13:0] d;
            d = ang_ref - meas;
            err_sum = err_sum + 32'(signed'(d));
            count = count + 1;
            sub = SUB_SAMPLE;
        endfunction

        function void calib_tick(logic [31:0] now, logic [13:0] meas);
            logic signed [31:0] q;
            case (sub)
                SUB_HOLD_THIRD: if (timed_out(now, 32'(init_dly))) begin
                    ang_ref = 0; sub = SUB_HOLD_ZERO; t_start = now;
                end
                SUB_HOLD_ZERO: if (timed_out(now, 32'(init_dly))) sample_angle(meas);
                SUB_SAMPLE: begin
                    if (count < nsamp) begin
                        if (count < nsamp / 2) ang_ref = ang_ref + astep;
                        else ang_ref = ang_ref - astep;
                        sub = SUB_STEP; t_start = now;
                    end else begin
                        q = 0;
                        if (count != 0) q = err_sum / $signed({19'd0, count});
                        offset = q[13:0]; offok = 1;
                        to_disarmed();
                        sub = SUB_NULL;
                    end
                end
                SUB_STEP: if (timed_out(now, 32'(step_dly))) sample_angle(meas);
                default: ;
            endcase
        endfunction

        // Apply one accepted event word and queue the resulting status word
        function void note_event(logic [IN_DATA_W-1:0] w);
            logic [2:0]  op, kind;
            logic [31:0] now, mech;
            logic [13:0] meas;
            logic signed [15:0] iq;
            logic        brk;
            logic [OUT_DATA_W-1:0] s;
            op = w[2:0]; now = w[34:3]; meas = w[48:35]; iq = w[64:49];
            mech = w[96:65]; kind = w[99:97]; brk = 0;
            case (op)
                OP_TICK: begin
                    if (top == ST_CAL) calib_tick(now, meas);
                    else if (top == ST_HOMING) begin
                        if (iq < 200 && iq > -200) t_start = now;
                        if (timed_out(now, STALL_HOLD)) begin
                            homeok = 1;
                            home_off = invert ? -mech : mech;
                            to_disarmed();
                        end
                    end else if (top == ST_ARMED) begin
                        if (timed_out(now, ARM_TMO)) begin
                            sticky = ERR_TIMEOUT; to_error();
                        end
                    end else if (top == ST_STARTUP) begin
                        to_disarmed(); sub = SUB_NULL;
                    end
                end
                OP_ERROR: if (top != ST_ERROR) begin
                    sticky = (kind >= 2 && kind <= 4) ? kind : ERR_OTHER;
                    to_error();
                end
                OP_DISARM: begin
                    if (top == ST_ARMED) to_disarmed();
                    else if (top == ST_ERROR) begin
                        to_disarmed(); sticky = ERR_OK; brk = 1;
                    end
                end
                OP_ARM: begin
                    if (top == ST_DISARMED) begin
                        foc = FOC_CURR; velmode = 0; vel_ref = 0;
                        top = ST_ARMED; t_start = now;
                    end else if (top == ST_ARMED) t_start = now;
                end
                OP_CAL: if (top == ST_DISARMED) begin
                    foc = FOC_VOLT; offok = 0; count = 0; err_sum = 0;
                    ang_ref = THIRD_TURN; top = ST_CAL; sub = SUB_HOLD_THIRD;
                    t_start = now;
                end
                OP_HOME: if (top == ST_DISARMED) begin
                    homeok = 0; home_off = 0; foc = FOC_CURR; velmode = 1;
                    vel_ref = hvel; top = ST_HOMING; t_start = now;
                end
                default: ;
            endcase
            s = '0;
            s[2:0] = top; s[4:3] = foc; s[5] = velmode; s[19:6] = ang_ref;
            s[35:20] = vel_ref; s[67:36] = home_off; s[68] = clr; s[69] = brk;
            s[72:70] = sticky; s[73] = offok; s[74] = homeok; s[88:75] = offset;
            status_q.push_back(s);
        endfunction

        // Compare one status word with the oldest expectation
        function void check_status(logic [OUT_DATA_W-1:0] got);
            logic [OUT_DATA_W-1:0] want;
            logic [31:0] fe, fg, msk;
            if (status_q.size() == 0) begin
                $display("%0t: unexpected status word %h", $realtime, got);
                n_fail++;
                return;
            end
            want = status_q.pop_front();
            for (int i = 0; i < NUM_FLD; i++) begin
                msk = (FLD_WID[i] == 32) ? 32'hFFFF_FFFF : (32'd1 << FLD_WID[i]) - 1;
                fe = 32'(want >> FLD_LSB[i]) & msk;
                fg = 32'(got >> FLD_LSB[i]) & msk;
                if (fe !== fg) begin
                    $display("%0t: field %0d expected %h actual %h", $realtime, i, fe, fg);
                    n_fail++;
                end
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    status_scoreboard sb = new();
    int          idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
    logic [31:0] tnow = 0;
    int          quiet = 0;

    motor_supervisor_fsm_top i_dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Receiver backpressure: 69 percent alone, 17 percent when both sides idle
    always @(posedge i_clk)
        m_axis_tready <= (idle_mode == 2) ? ($urandom_range(0, 99) >= 69) :
                         (idle_mode == 3) ? ($urandom_range(0, 99) >= 17) : 1'b1;

    // Status checking
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);

    // Watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Write enable stays high across a burst; the caller drops it afterwards
    task automatic write_cfg(t_reg_idx idx, logic [15:0] d);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        sb.write_reg(idx, d);
    endtask

    // Wait until all status words are in, then cover the divider latency
    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.status_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_event(logic [2:0] op, logic [31:0] dt, logic [13:0] ang,
                              logic [15:0] iq, logic [31:0] mech, logic [2:0] kind);
        logic [IN_DATA_W-1:0] w;
        int                   pct;
        pct = (idle_mode == 1) ? 69 : 17;
        if (idle_mode == 1 || idle_mode == 3) begin
            if ($urandom_range(0, 99) < pct) begin
                s_axis_tvalid <= 0;
                @(posedge i_clk);
                while ($urandom_range(0, 99) < pct) @(posedge i_clk);
            end
        end
        tnow = tnow + dt;
        w = '0;
        w[2:0] = op; w[34:3] = tnow; w[48:35] = ang; w[64:49] = iq;
        w[96:65] = mech; w[99:97] = kind;
        s_axis_tvalid <= 1;
        s_axis_tdata <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_event(w);
    endtask

    task automatic random_event(int dt_max);
        int          r;
        logic [2:0]  op;
        logic [31:0] dt;
        logic [15:0] iq;
        r = $urandom_range(0, 99);
        if (r < 72) op = OP_TICK;
        else if (r < 75) op = OP_ERROR;
        else if (r < 81) op = OP_DISARM;
        else if (r < 87) op = OP_ARM;
        else if (r < 93) op = OP_CAL;
        else if (r < 98) op = OP_HOME;
        else op = 3'($urandom_range(6, 7));
        r = $urandom_range(0, 99);
        if (r < 85) dt = $urandom_range(0, dt_max);
        else if (r < 98) dt = $urandom_range(400, 1300);
        else dt = $urandom;
        // mostly stall-level current so homing can complete
        iq = 16'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            iq = 16'($urandom_range(200, 32767));
            if ($urandom_range(0, 1)) iq = -iq;
        end
        send_event(op, dt, 14'($urandom), iq, $urandom, 3'($urandom));
    endtask

    initial begin
        logic [15:0] cfg [5][6];
        int dtm [5];
        cfg[0] = '{16'd1, 16'd0, 16'd0, 16'd1, 16'd16383, 16'h8000};
        cfg[1] = '{16'd0, 16'd20, 16'd3, 16'd7, 16'd100, 16'h7FFF};
        cfg[2] = '{16'd1, 16'd65535, 16'd65535, 16'd4096, 16'd0, 16'd0};
        cfg[3] = '{16'd0, 16'd5, 16'd1, 16'd12, 16'd8191, 16'hFF9C};
        cfg[4] = '{16'd1, 16'd2, 16'd2, 16'd4, 16'd1, 16'h0001};
        dtm = '{4, 30, 3000, 10, 6};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: state walk with the reset configuration
        send_event(OP_TICK, 1, 0, 0, 0, 0);
        send_event(3'd6, 1, 14'h3FFF, 16'hFFFF, 32'hFFFF_FFFF, 3'd7);
        send_event(OP_ERROR, 1, 0, 0, 0, 3'd0);
        send_event(OP_ERROR, 1, 0, 0, 0, ERR_SIGNAL);
        send_event(OP_DISARM, 1, 0, 0, 0, 0);
        send_event(OP_ARM, 1, 0, 0, 0, 0);
        send_event(OP_ARM, 5, 0, 0, 0, 0);
        send_event(OP_TICK, 1001, 0, 0, 0, 0);
        send_event(OP_DISARM, 1, 0, 0, 0, 0);
        send_event(OP_HOME, 1, 0, 16'h8000, 0, 0);
        send_event(OP_TICK, 300, 0, 16'h7FFF, 32'h8000_0000, 0);
        send_event(OP_TICK, 300, 0, 16'hFF38, 32'h8000_0000, 0);
        send_event(OP_ERROR, 1, 0, 0, 0, ERR_LINK);
        send_event(OP_DISARM, 1, 0, 0, 0, 0);
        send_event(OP_CAL, 1, 0, 0, 0, 0);
        send_event(OP_TICK, 501, 0, 0, 0, 0);
        drain();

        // Directed: single-sample calibration, inverted homing at min offset
        write_cfg(REG_NSAMP, 16'd0);
        write_cfg(REG_INIT_DLY, 16'd0);
        write_cfg(REG_STEP_DLY, 16'd0);
        write_cfg(REG_INVERT, 16'd1);
        i_cfg_we <= 0;
        send_event(OP_TICK, 1, 14'h2000, 0, 0, 0);
        send_event(OP_TICK, 1, 0, 0, 0, 0);
        send_event(OP_HOME, 1, 0, 0, 0, 0);
        send_event(OP_TICK, 1, 0, 16'd199, 0, 0);
        send_event(OP_TICK, 501, 0, 16'd200, 32'h8000_0000, 0);
        drain();

        // Random phases over several configurations and idle patterns
        for (int p = 0; p < 5; p++) begin
            for (int k = 0; k < 6; k++) write_cfg(t_reg_idx'(k), cfg[p][k]);
            i_cfg_we <= 0;
            if (p == 3) tnow = 32'hFFFF_F000;
            for (int n = 0; n < 320; n++) begin
                idle_mode = ((n / 80) + p) % 4;
                random_event(dtm[p]);
            end
            idle_mode = 0;
            drain();
        end

        if (sb.n_fail == 0 && sb.status_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
